### rtl/gdm_pkg.sv
// ----------------------------------------------------------------------------
// Disc-mean downsampler package
// Shared constants and the item type for the disc-mean grid downsampler.
// ----------------------------------------------------------------------------
package gdm_pkg;

	localparam int MAX_COLS_DEF       = 256;
	localparam int MAX_ROWS_DEF       = 256;
	localparam int MAX_HALF_WIDTH_DEF = 7;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FACTOR      = 2'd2;
	localparam logic [1:0] REG_MISSING     = 2'd3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// One item as it travels from the front part to the back part.
	typedef struct packed {
		logic        op;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [15:0] sample;
	} item_t;

endpackage

### rtl/gdm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gdm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/gdm_fifo.sv
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue that parts the front part from the back part.
// ----------------------------------------------------------------------------
module gdm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gdm_pkg::item_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output gdm_pkg::item_t  out_item
);

	gdm_pkg::item_t slot_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = slot_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= in_item;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !in_ready) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_pop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 2'd1)
		else $error("queue count lost on pop");
`endif

endmodule

### rtl/gdm_engine.sv
// ----------------------------------------------------------------------------
// Disc-mean engine
// Writes loads into the plane store and walks the disc for queries,
// then divides by a restoring divider and holds the result for output.
// ----------------------------------------------------------------------------
module gdm_engine #(
	parameter int MAX_COLS       = gdm_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS       = gdm_pkg::MAX_ROWS_DEF,
	parameter int MAX_HALF_WIDTH = gdm_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  gdm_pkg::item_t        item,
	input  logic [8:0]            grid_width,
	input  logic [8:0]            grid_height,
	input  logic [7:0]            reduction_factor,
	input  logic signed [15:0]    missing_code,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic signed [15:0]    res_mean,
	output logic                  res_has_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = CW + RW;
	localparam int HW = $clog2(MAX_HALF_WIDTH + 1) + 1;
	localparam int DIAM = 2 * MAX_HALF_WIDTH + 1;
	localparam int NW = $clog2(DIAM * DIAM + 1);
	localparam int SW = 16 + NW + 1;
	localparam int QW = SW + 1;
	localparam int DCW = $clog2(QW + 1);
	localparam int XW = 14;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SETUP, ST_WALK, ST_DRAIN, ST_DIV, ST_OUT
	} state_t;

	state_t                state_q;
	logic signed [HW-1:0]  half_q;
	logic signed [HW-1:0]  dx_q, dy_q;
	logic signed [XW-1:0]  cx_q, cy_q;
	logic [12:0]           w_q, h_q;
	logic [22:0]           lim_q;
	logic signed [SW-1:0]  sum_q;
	logic [NW-1:0]         cnt_q;
	logic                  rd_s1;
	logic [QW-1:0]         rem_q, quo_q, num_q;
	logic [DCW-1:0]        dcnt_q;
	logic                  neg_q;
	logic [7:0]            qcol_q, qrow_q;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [15:0]           rd_data;
	logic signed [XW-1:0]  jx, jy;
	logic [HW*2-1:0]       r2;
	logic                  in_disc, in_grid;
	logic                  last_off;
	logic [QW-1:0]         den2, rem_sh;
	logic signed [15:0]    v;
	logic [15:0]           cx_raw, cy_raw;
	logic [8:0]            half_raw;

	assign item_ready = (state_q == ST_IDLE);
	assign wr_en = item_valid && item_ready && item.op == gdm_pkg::OP_LOAD
		&& 32'(item.col) < MAX_COLS && 32'(item.row) < MAX_ROWS;
	assign wr_addr = {RW'(item.row), CW'(item.col)};

	assign jx = cx_q + XW'(dx_q);
	assign jy = cy_q + XW'(dy_q);
	assign r2 = (HW*2)'(dx_q * dx_q) + (HW*2)'(dy_q * dy_q);
	assign in_disc = (32'(r2) * 32'd25600) <= 32'(lim_q);
	assign in_grid = jx >= 0 && jy >= 0 && jx < XW'(w_q) && jy < XW'(h_q);
	assign rd_addr = {jy[RW-1:0], jx[CW-1:0]};
	assign last_off = (dx_q == half_q) && (dy_q == half_q);
	assign v = rd_data;
	assign den2 = QW'({cnt_q, 1'b0});
	assign rem_sh = {rem_q[QW-2:0], num_q[QW-1]};
	assign cx_raw = 16'(qcol_q) * 16'(reduction_factor) + 16'd8;
	assign cy_raw = 16'(qrow_q) * 16'(reduction_factor) + 16'd8;
	assign half_raw = 9'(reduction_factor) + 9'd8;

	gdm_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item.sample),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			res_valid    <= 1'b0;
			rd_s1        <= 1'b0;
		end else begin
			rd_s1 <= 1'b0;
			if (rd_s1 && v != missing_code) begin
				sum_q <= sum_q + SW'(v);
				cnt_q <= cnt_q + NW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid && item.op == gdm_pkg::OP_QUERY) begin
						qcol_q  <= item.col;
						qrow_q  <= item.row;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					w_q <= ({4'd0, grid_width} > 13'(MAX_COLS)) ? 13'(MAX_COLS)
						: {4'd0, grid_width};
					h_q <= ({4'd0, grid_height} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
						: {4'd0, grid_height};
					cx_q <= XW'(cx_raw[15:4]);
					cy_q <= XW'(cy_raw[15:4]);
					if (half_raw[8:4] <= 5'd2) begin
						half_q <= HW'(1);
						dx_q <= -HW'(1);
						dy_q <= -HW'(1);
					end else if (half_raw[8:4] - 5'd1 > 5'(MAX_HALF_WIDTH)) begin
						half_q <= HW'(MAX_HALF_WIDTH);
						dx_q <= -HW'(MAX_HALF_WIDTH);
						dy_q <= -HW'(MAX_HALF_WIDTH);
					end else begin
						half_q <= HW'(half_raw[8:4] - 5'd1);
						dx_q <= -HW'(half_raw[8:4] - 5'd1);
						dy_q <= -HW'(half_raw[8:4] - 5'd1);
					end
					lim_q <= (reduction_factor >= 8'd16)
						? 23'(11 * (reduction_factor - 8'd16)) * 23'(11 * (reduction_factor - 8'd16))
						: 23'd0;
					sum_q <= '0;
					cnt_q <= '0;
					if (reduction_factor < 8'd16) begin
						state_q <= ST_DRAIN;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (cx_q >= XW'(w_q) || cy_q >= XW'(h_q)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_s1 <= in_disc && in_grid;
						if (last_off) begin
							state_q <= ST_DRAIN;
						end else if (dx_q == half_q) begin
							dx_q <= -half_q;
							dy_q <= dy_q + HW'(1);
						end else begin
							dx_q <= dx_q + HW'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (!rd_s1) begin
						neg_q  <= sum_q[SW-1];
						num_q  <= sum_q[SW-1] ? QW'(-{sum_q, 1'b0}) + QW'(cnt_q)
							: QW'({sum_q, 1'b0}) + QW'(cnt_q);
						rem_q  <= '0;
						quo_q  <= '0;
						dcnt_q <= DCW'(QW);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					num_q <= {num_q[QW-2:0], 1'b0};
					if (rem_sh >= den2) begin
						rem_q <= rem_sh - den2;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - DCW'(1);
					if (dcnt_q == DCW'(1) || cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid) begin
						res_valid <= 1'b1;
						if (cnt_q == '0) begin
							res_mean     <= missing_code;
							res_has_data <= 1'b0;
						end else begin
							res_mean     <= neg_q ? -quo_q[15:0] : quo_q[15:0];
							res_has_data <= 1'b1;
						end
					end else if (res_ready) begin
						res_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !item_ready) else $error("item taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_mean))
		else $error("result dropped");
	a_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_has_data |-> res_mean == missing_code)
		else $error("empty result not missing code");
`endif

endmodule

### rtl/grid_downsample_disk_mean.sv
// ----------------------------------------------------------------------------
// Disc-mean grid downsampler
// Stores a plane of samples and returns the disc mean of reduced pixels.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser carries op, tdata carries col,
// row and sample. A load (op 0) writes one sample and gives no result. A
// query (op 1) gives one result on m_axis: tdata carries the mean, tuser
// the has-data flag. The front part takes items into a two-entry queue;
// the back part writes loads and walks a query's disc one offset per cycle
// through the plane store's single read port, then runs a one-bit-per-cycle
// divider. Reset clears the control state and sets the registers to their
// defaults; the plane store is not cleared. When the receiver stalls,
// the result is held and the back part waits; the queue then fills
// and s_axis_tready falls. Configuration is to be written on the
// cfg_valid/cfg_ready channel only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module grid_downsample_disk_mean #(
	parameter int MAX_COLS       = gdm_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS       = gdm_pkg::MAX_ROWS_DEF,
	parameter int MAX_HALF_WIDTH = gdm_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // col [7:0], row [15:8], sample [31:16]
	input  logic        s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // mean_value
	output logic        m_axis_tuser,  // has_data
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [8:0]         grid_width_q, grid_height_q;
	logic [7:0]         factor_q;
	logic signed [15:0] missing_q;
	gdm_pkg::item_t     in_item, q_item;
	logic               q_valid, q_ready;
	logic signed [15:0] mean;

	assign cfg_ready = 1'b1;
	assign in_item.op     = s_axis_tuser;
	assign in_item.col    = s_axis_tdata[7:0];
	assign in_item.row    = s_axis_tdata[15:8];
	assign in_item.sample = s_axis_tdata[31:16];
	assign m_axis_tdata   = mean;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 9'd256;
			grid_height_q <= 9'd256;
			factor_q      <= 8'd32;
			missing_q     <= 16'sh8000;
		end else if (cfg_valid) begin
			case (cfg_index)
				gdm_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[8:0];
				gdm_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[8:0];
				gdm_pkg::REG_FACTOR:      factor_q      <= cfg_data[7:0];
				gdm_pkg::REG_MISSING:     missing_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	gdm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	gdm_engine #(
		.MAX_COLS       (MAX_COLS),
		.MAX_ROWS       (MAX_ROWS),
		.MAX_HALF_WIDTH (MAX_HALF_WIDTH)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (q_valid),
		.item_ready       (q_ready),
		.item             (q_item),
		.grid_width       (grid_width_q),
		.grid_height      (grid_height_q),
		.reduction_factor (factor_q),
		.missing_code     (missing_q),
		.res_valid        (m_axis_tvalid),
		.res_ready        (m_axis_tready),
		.res_mean         (mean),
		.res_has_data     (m_axis_tuser)
	);

endmodule
